// ===== hw/rtl/lru_rect_residency_cache_macros.svh =====
// Assertion macros used by the residency cache checker.
// Needs nothing else; include by bare file name.
`ifndef LRU_RECT_RESIDENCY_CACHE_MACROS_SVH
`define LRU_RECT_RESIDENCY_CACHE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LRC_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/lrc_pkg.sv =====
// Shared types and constants for the sprite rectangle residency cache.
// No dependencies.
`default_nettype none

package lrc_pkg;

    // Table geometry
    localparam int SLOT_COUNT  = 40;
    localparam int SHEET_COUNT = 12;
    localparam int SLOT_W      = $clog2(SLOT_COUNT);
    localparam int CNT_W       = $clog2(SLOT_COUNT + 1);

    // Field widths
    localparam int HANDLE_W  = 5;
    localparam int COORD_W   = 10;
    localparam int BOUND_W   = 4;
    localparam int BOX_W_W   = 9;
    localparam int BOX_H_W   = 8;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 9;
    localparam int OUT_SLOT_W = 6;
    localparam int OUTCOME_W = 3;

    // Tag layout: {handle[3:0], x, y, w, h}
    localparam int TAG_W     = 44;
    localparam int TAG_H_LSB = 0;
    localparam int TAG_W_LSB = 10;
    localparam int STAMP_W   = 32;
    localparam int ENTRY_W   = TAG_W + STAMP_W;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOUND_SHEETS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_WIDTH    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BOX_HEIGHT   = 2'd2;

    // Result codes
    typedef enum logic [OUTCOME_W-1:0] {
        OC_HIT      = 3'd0,
        OC_COLD     = 3'd1,
        OC_EVICT    = 3'd2,
        OC_UNBOUND  = 3'd3,
        OC_OVERSIZE = 3'd4,
        OC_FETCH    = 3'd5,
        OC_ALLOC    = 3'd6
    } t_outcome;

    // Control sequencer
    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE
    } t_state;

endpackage

`default_nettype wire

// ===== hw/rtl/lru_rect_residency_cache.sv =====
// Fully associative LRU residency cache for sprite rectangles.
// Unbound requests and an empty table go straight to decide; else the walk reads
// filled slots (at most 40) from slot 0, one per cycle, until a hit or the last.
// busy stays high from accept until the result beat; the next item may start
// in the cycle the result strobe is high. Results cannot be stalled.
// Reset (i_rst_n low, synchronous) empties the table and restores the registers.
`default_nettype none

module lru_rect_residency_cache (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [lrc_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [lrc_pkg::CFG_DAT_W-1:0] i_cfg_data,
    // request
    input  wire logic                          start,
    output      logic                          busy,
    input  wire logic [lrc_pkg::HANDLE_W-1:0]  i_sheet_handle,
    input  wire logic [lrc_pkg::COORD_W-1:0]   i_src_x,
    input  wire logic [lrc_pkg::COORD_W-1:0]   i_src_y,
    input  wire logic [lrc_pkg::COORD_W-1:0]   i_rect_width,
    input  wire logic [lrc_pkg::COORD_W-1:0]   i_rect_height,
    input  wire logic                          i_source_ok,
    input  wire logic                          i_alloc_ok,
    // result
    output      logic                          o_valid,
    output      logic [lrc_pkg::OUT_SLOT_W-1:0] o_slot_index,
    output      logic [lrc_pkg::OUTCOME_W-1:0] o_outcome
);
    import lrc_pkg::*;

    // configuration
    logic [BOUND_W-1:0] r_bound_sheets;
    logic [BOX_W_W-1:0] r_box_width;
    logic [BOX_H_W-1:0] r_box_height;

    // request context
    t_state             r_state, n_state;
    logic [TAG_W-1:0]   r_tag;
    logic               r_unbound;
    logic               r_src_ok;
    logic               r_alloc_ok;

    // table bookkeeping
    logic [CNT_W-1:0]   r_filled;
    logic [STAMP_W-1:0] r_use_clk;
    logic [SLOT_W-1:0]  r_idx;
    logic [STAMP_W-1:0] r_min_stamp;
    logic [SLOT_W-1:0]  r_min_idx;

    // result register
    logic                  r_out_valid;
    logic [OUT_SLOT_W-1:0] r_out_slot;
    t_outcome              r_out_code;

    // slot table: {tag, stamp} per entry
    logic [ENTRY_W-1:0] r_mem [SLOT_COUNT];
    logic [ENTRY_W-1:0] r_rd_data;

    // datapath / control signals
    logic               accept;
    logic [BOUND_W:0]   bound_eff;
    logic               req_unbound;
    logic [TAG_W-1:0]   rd_tag;
    logic [STAMP_W-1:0] rd_stamp;
    logic               scan_hit;
    logic               scan_last;
    logic               oversize;
    logic               table_full;
    logic [STAMP_W-1:0] stamp_next;

    logic               rd_en;
    logic [SLOT_W-1:0]  rd_addr;
    logic               mem_we;
    logic [SLOT_W-1:0]  mem_waddr;
    logic               fill_inc;
    logic               res_valid;
    logic [SLOT_W-1:0]  res_slot;
    t_outcome           res_code;

    assign accept = start && !busy;
    assign busy   = (r_state != S_IDLE);

    // effective bound count saturates at the sheet count
    always_comb begin
        if ({1'b0, r_bound_sheets} > (BOUND_W+1)'(SHEET_COUNT)) begin
            bound_eff = (BOUND_W+1)'(SHEET_COUNT);
        end else begin
            bound_eff = {1'b0, r_bound_sheets};
        end
    end

    assign req_unbound = i_sheet_handle[HANDLE_W-1] ||
                         ({1'b0, i_sheet_handle[HANDLE_W-2:0]} >= bound_eff);

    assign rd_tag    = r_rd_data[ENTRY_W-1 -: TAG_W];
    assign rd_stamp  = r_rd_data[STAMP_W-1:0];
    assign scan_hit  = (rd_tag == r_tag);
    assign scan_last = ((CNT_W'(r_idx) + CNT_W'(1)) == r_filled);

    assign oversize = (r_tag[TAG_W_LSB +: COORD_W] > COORD_W'(r_box_width)) ||
                      (r_tag[TAG_H_LSB +: COORD_W] > COORD_W'(r_box_height));
    assign table_full = (r_filled == CNT_W'(SLOT_COUNT));
    assign stamp_next = r_use_clk + STAMP_W'(1);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (req_unbound || (r_filled == '0)) begin
                        n_state = S_DECIDE;
                    end else begin
                        n_state = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    n_state = S_IDLE;
                end else if (scan_last) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        rd_en     = 1'b0;
        rd_addr   = '0;
        mem_we    = 1'b0;
        mem_waddr = '0;
        fill_inc  = 1'b0;
        res_valid = 1'b0;
        res_slot  = '0;
        res_code  = OC_HIT;
        unique case (r_state)
            S_IDLE: begin
                // prefetch slot 0 with the accepted beat
                if (accept && !req_unbound && (r_filled != '0)) begin
                    rd_en = 1'b1;
                end
            end
            S_SCAN: begin
                if (scan_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_idx;
                    res_valid = 1'b1;
                    res_slot  = r_idx;
                    res_code  = OC_HIT;
                end else if (!scan_last) begin
                    rd_en   = 1'b1;
                    rd_addr = r_idx + SLOT_W'(1);
                end
            end
            S_DECIDE: begin
                res_valid = 1'b1;
                priority if (r_unbound) begin
                    res_code = OC_UNBOUND;
                end else if (oversize) begin
                    res_code = OC_OVERSIZE;
                end else if (!r_src_ok) begin
                    res_code = OC_FETCH;
                end else if (!table_full && !r_alloc_ok) begin
                    res_code = OC_ALLOC;
                end else if (!table_full) begin
                    res_code  = OC_COLD;
                    mem_we    = 1'b1;
                    mem_waddr = r_filled[SLOT_W-1:0];
                    res_slot  = r_filled[SLOT_W-1:0];
                    fill_inc  = 1'b1;
                end else begin
                    res_code  = OC_EVICT;
                    mem_we    = 1'b1;
                    mem_waddr = r_min_idx;
                    res_slot  = r_min_idx;
                end
            end
            default: ;
        endcase
    end

    // slot table: one write and one registered read per cycle
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= {r_tag, stamp_next};
        end
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_filled       <= '0;
            r_use_clk      <= '0;
            r_out_valid    <= 1'b0;
            r_bound_sheets <= '0;
            r_box_width    <= BOX_W_W'(64);
            r_box_height   <= BOX_H_W'(64);
        end else begin
            r_state     <= n_state;
            r_out_valid <= res_valid;
            if (mem_we) begin
                r_use_clk <= stamp_next;
            end
            if (fill_inc) begin
                r_filled <= r_filled + CNT_W'(1);
            end
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BOUND_SHEETS: r_bound_sheets <= i_cfg_data[BOUND_W-1:0];
                    CFG_BOX_WIDTH:    r_box_width    <= i_cfg_data[BOX_W_W-1:0];
                    CFG_BOX_HEIGHT:   r_box_height   <= i_cfg_data[BOX_H_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // request capture, walk index and LRU tracking
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_tag      <= {i_sheet_handle[HANDLE_W-2:0], i_src_x, i_src_y,
                           i_rect_width, i_rect_height};
            r_unbound  <= req_unbound;
            r_src_ok   <= i_source_ok;
            r_alloc_ok <= i_alloc_ok;
            r_idx      <= '0;
        end else if ((r_state == S_SCAN) && rd_en) begin
            r_idx <= r_idx + SLOT_W'(1);
        end
        // strict compare keeps the lowest index on a tie
        if (r_state == S_SCAN) begin
            if ((r_idx == '0) || (rd_stamp < r_min_stamp)) begin
                r_min_stamp <= rd_stamp;
                r_min_idx   <= r_idx;
            end
        end
        if (res_valid) begin
            r_out_slot <= OUT_SLOT_W'(res_slot);
            r_out_code <= res_code;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_slot_index = r_out_slot;
    assign o_outcome    = r_out_code;

endmodule

`default_nettype wire

// ===== hw/rtl/lrc_checker.sv =====
// Port-level checker for the residency cache, bound to the top level.
// Depends on lrc_pkg and lru_rect_residency_cache_macros.svh.
`default_nettype none

`include "lru_rect_residency_cache_macros.svh"

module lrc_checker (
    input wire logic                           i_clk,
    input wire logic                           i_rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic                           o_valid,
    input wire logic [lrc_pkg::OUT_SLOT_W-1:0] o_slot_index,
    input wire logic [lrc_pkg::OUTCOME_W-1:0]  o_outcome
);
    import lrc_pkg::*;

    logic is_drop;

    // result beat carries one of the drop codes
    assign is_drop = o_valid && ((o_outcome == OC_UNBOUND) || (o_outcome == OC_OVERSIZE) ||
                                 (o_outcome == OC_FETCH) || (o_outcome == OC_ALLOC));

    // an accepted beat always leaves the block busy in the next cycle
    `LRC_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, start && !busy, busy, "accept without busy")

    // a result beat closes the item: the block is free again
    `LRC_ASSERT_SAME(a_result_idle, i_clk, i_rst_n, o_valid, !busy, "result while busy")

    // at most one result per item, never on consecutive cycles
    `LRC_ASSERT_NEXT(a_single_result, i_clk, i_rst_n, o_valid, !o_valid, "repeated result")

    // every drop reports slot zero
    `LRC_ASSERT_SAME(a_drop_slot, i_clk, i_rst_n, is_drop, o_slot_index == '0, "drop slot")

endmodule

bind lru_rect_residency_cache lrc_checker u_lrc_checker (.*);

`default_nettype wire
